>>> rtl/hdcvt_pkg.sv
// ============================================================================
// hdcvt_pkg: shared definitions for the class vector trainer
// Field widths, register indexes, reset values, default parameters and the
// sequencer state type.
// ============================================================================
package hdcvt_pkg;

   // Default sizing of the trainer.
   localparam int MAX_CLASSES_DEF   = 16;
   localparam int MAX_DIM_WORDS_DEF = 32;
   localparam int LANES_DEF         = 32;
   localparam int COUNTER_WIDTH_DEF = 16;

   // Word field widths.
   localparam int LABEL_W    = 8;
   localparam int CHUNK_W    = 32;
   localparam int POS_W      = 5;
   localparam int SAMPLE_W   = 16;
   localparam int ACTIVE_W   = 5;
   localparam int DIMW_W     = 6;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_CLASSES = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_WORDS      = 8'd1;

   // Register reset values.
   localparam logic [ACTIVE_W-1:0] ACTIVE_CLASSES_RST = 5'd16;
   localparam logic [DIMW_W-1:0]   DIM_WORDS_RST      = 6'd32;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

>>> rtl/hdcvt_if.sv
// ============================================================================
// hdcvt channel interfaces
// Valid/ready channels for training chunks, results and register writes.
// ============================================================================
interface hdcvt_req_if;
   logic                            valid;
   logic                            ready;
   logic [hdcvt_pkg::LABEL_W-1:0]   train_label;
   logic [hdcvt_pkg::CHUNK_W-1:0]   chunk_bits;

   modport source (output valid, train_label, chunk_bits, input ready);
   modport sink   (input valid, train_label, chunk_bits, output ready);
endinterface

interface hdcvt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hdcvt_pkg::LABEL_W-1:0]   label_echo;
   logic [hdcvt_pkg::POS_W-1:0]     chunk_position;
   logic [hdcvt_pkg::CHUNK_W-1:0]   class_bits;
   logic                            accepted;
   logic                            vector_done;
   logic [hdcvt_pkg::SAMPLE_W-1:0]  sample_count;

   modport source (output valid, label_echo, chunk_position, class_bits, accepted,
                   vector_done, sample_count, input ready);
   modport sink   (input valid, label_echo, chunk_position, class_bits, accepted,
                   vector_done, sample_count, output ready);
endinterface

interface hdcvt_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hdcvt_pkg::CSR_INDEX_W-1:0] index;
   logic [hdcvt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/hd_class_vector_trainer_core.sv
// ============================================================================
// hd_class_vector_trainer_core: binary hyperdimensional class vector trainer
// Accumulates training chunks into per-class dimension counters and returns
// the binarized class vector bits of each chunk.
// ============================================================================
// Result path: a result word is registered first in the memory read stage and then in
//    the output register, and waits longer only while the previous result holds it.
// Flow: a new chunk is taken only once the previous one is written back, since
//    each chunk reads and writes back one counter memory row.
// Reset: a clearing pass over all MAX_CLASSES * MAX_DIM_WORDS rows (512 by default)
//    zeroes the counter memory; chunks are not taken during it, register writes are.
module hd_class_vector_trainer_core #(
   parameter int MAX_CLASSES   = hdcvt_pkg::MAX_CLASSES_DEF,
   parameter int MAX_DIM_WORDS = hdcvt_pkg::MAX_DIM_WORDS_DEF,
   parameter int LANES         = hdcvt_pkg::LANES_DEF,
   parameter int COUNTER_WIDTH = hdcvt_pkg::COUNTER_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   hdcvt_req_if.sink   req_ch,
   hdcvt_rsp_if.source rsp_ch,
   hdcvt_csr_if.sink   csr_ch
);

   // One memory row holds the counters of all lanes of one chunk of one class.
   localparam int DEPTH  = MAX_CLASSES * MAX_DIM_WORDS;
   localparam int AW     = $clog2(DEPTH);
   localparam int CLW    = $clog2(MAX_CLASSES);
   localparam int PW     = (MAX_DIM_WORDS > 1) ? $clog2(MAX_DIM_WORDS) : 1;
   localparam int WCW    = $clog2(MAX_DIM_WORDS + 1);
   // Word count arithmetic is wide enough for both the register and the limit.
   localparam int CW     = (WCW > hdcvt_pkg::DIMW_W) ? WCW : hdcvt_pkg::DIMW_W;
   localparam int ROW_W  = LANES * COUNTER_WIDTH;
   localparam int LCMP_W = hdcvt_pkg::LABEL_W + 1;
   localparam logic [COUNTER_WIDTH-1:0] SAT_MAX = '1;

   // ---------------------------------------------------------------------------
   // Configuration registers. The port is always ready; an index other than
   // the two defined registers is dropped.
   // ---------------------------------------------------------------------------
   logic [hdcvt_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [hdcvt_pkg::DIMW_W-1:0]   dim_ff, dim_in;
   logic                           csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   always_comb begin
      active_in = active_ff;
      dim_in    = dim_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            hdcvt_pkg::REG_ACTIVE_CLASSES: active_in = csr_ch.data[hdcvt_pkg::ACTIVE_W-1:0];
            hdcvt_pkg::REG_DIM_WORDS:      dim_in    = csr_ch.data[hdcvt_pkg::DIMW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= hdcvt_pkg::ACTIVE_CLASSES_RST;
         dim_ff    <= hdcvt_pkg::DIM_WORDS_RST;
      end else begin
         active_ff <= active_in;
         dim_ff    <= dim_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer state and handshake.
   // ---------------------------------------------------------------------------
   hdcvt_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 req_fire;
   logic                 out_free;
   logic                 clr_last;
   logic                 mem_rd_en;
   logic                 mem_wr_en;
   logic                 load_out;
   logic                 clearing;
   logic                 rsp_valid_ff, rsp_valid_in;

   // The output register is free when it is empty or its word leaves this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign clr_last = (clr_ff == AW'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hdcvt_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = hdcvt_pkg::ST_IDLE;
            end
         end
         hdcvt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = hdcvt_pkg::ST_UPDATE;
            end
         end
         hdcvt_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = hdcvt_pkg::ST_IDLE;
            end
         end
         default: state_in = hdcvt_pkg::ST_CLEAR;
      endcase
   end

   // Stage registers carry one chunk from its memory read to its write-back.
   logic [hdcvt_pkg::LABEL_W-1:0] st_label_ff;
   logic [hdcvt_pkg::CHUNK_W-1:0] st_bits_ff;
   logic [PW-1:0]                 st_pos_ff;
   logic                          st_ok_ff;
   logic                          st_last_ff;
   logic [COUNTER_WIDTH-1:0]      st_n_ff;
   logic [AW-1:0]                 st_addr_ff;

   always_comb begin
      req_ch.ready = 1'b0;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      load_out     = 1'b0;
      clearing     = 1'b0;
      case (state_ff)
         hdcvt_pkg::ST_CLEAR: begin
            clearing  = 1'b1;
            mem_wr_en = 1'b1;
         end
         hdcvt_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            mem_rd_en    = req_ch.valid;
         end
         hdcvt_pkg::ST_UPDATE: begin
            load_out  = out_free;
            mem_wr_en = out_free && st_ok_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      if (clearing && !clr_last) begin
         clr_in = clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdcvt_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Chunk position, label check and sample counts, all settled at acceptance.
   // ---------------------------------------------------------------------------
   logic [PW-1:0]            pos_ff, pos_in;
   logic [CW-1:0]            dim_ext;
   logic [CW-1:0]            word_count;
   logic [CW-1:0]            pos_next;
   logic                     last;
   logic                     ok;
   logic [CLW-1:0]           lbl_idx;
   logic [COUNTER_WIDTH-1:0] sc_ff [MAX_CLASSES];
   logic [COUNTER_WIDTH-1:0] n_cur;
   logic [AW-1:0]            row_addr;

   // A zero word count acts as one word, and a count above the limit as the limit.
   assign dim_ext = CW'(dim_ff);
   always_comb begin
      word_count = dim_ext;
      if (dim_ext == '0) begin
         word_count = CW'(1);
      end else if (dim_ext > CW'(MAX_DIM_WORDS)) begin
         word_count = CW'(MAX_DIM_WORDS);
      end
   end

   // The position can sit past the word count after the count was lowered;
   // that chunk then closes the vector.
   assign pos_next = CW'(pos_ff) + CW'(1);
   assign last     = (pos_next >= word_count);
   assign ok       = (LCMP_W'(req_ch.train_label) < LCMP_W'(active_ff)) &&
                     (LCMP_W'(req_ch.train_label) < LCMP_W'(MAX_CLASSES));
   assign lbl_idx  = req_ch.train_label[CLW-1:0];
   assign n_cur    = (sc_ff[lbl_idx] == SAT_MAX) ? SAT_MAX
                                                 : sc_ff[lbl_idx] + COUNTER_WIDTH'(1);
   assign row_addr = AW'(AW'(lbl_idx) * AW'(MAX_DIM_WORDS) + AW'(pos_ff));

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         pos_in = last ? '0 : PW'(pos_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Only the label of a vector's last chunk gets its sample count raised.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CLASSES; c++) begin
            sc_ff[c] <= '0;
         end
      end else if (req_fire && ok && last) begin
         sc_ff[lbl_idx] <= n_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         st_label_ff <= req_ch.train_label;
         st_bits_ff  <= req_ch.chunk_bits;
         st_pos_ff   <= pos_ff;
         st_ok_ff    <= ok;
         st_last_ff  <= last;
         st_n_ff     <= n_cur;
         st_addr_ff  <= row_addr;
      end
   end

   // ---------------------------------------------------------------------------
   // Counter memory and lane arithmetic.
   // ---------------------------------------------------------------------------
   logic [ROW_W-1:0]         rd_row;
   logic [ROW_W-1:0]         upd_row;
   logic [ROW_W-1:0]         wr_row;
   logic [AW-1:0]            wr_addr;
   logic [LANES-1:0]         lane_bits;
   logic [LANES-1:0]         lane_class;
   logic [COUNTER_WIDTH-1:0] threshold;

   assign wr_addr   = clearing ? clr_ff : st_addr_ff;
   assign wr_row    = clearing ? '0 : upd_row;
   assign threshold = st_n_ff >> 1;

   // Lanes beyond the chunk width see zero input bits.
   for (genvar i = 0; i < LANES; i++) begin : g_lane_in
      if (i < hdcvt_pkg::CHUNK_W) begin : g_data
         assign lane_bits[i] = st_bits_ff[i];
      end else begin : g_zero
         assign lane_bits[i] = 1'b0;
      end
   end

   hdcvt_counter_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ROW_W),
      .AW    (AW)
   ) u_counter_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (mem_rd_en),
      .rd_addr (row_addr),
      .rd_data (rd_row)
   );

   hdcvt_lane_update #(
      .LANES         (LANES),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_lane_update (
      .rd_row     (rd_row),
      .lane_bits  (lane_bits),
      .threshold  (threshold),
      .wr_row     (upd_row),
      .lane_class (lane_class)
   );

   // ---------------------------------------------------------------------------
   // Output register. An ignored label reports zero class bits and count.
   // ---------------------------------------------------------------------------
   logic [hdcvt_pkg::CHUNK_W-1:0]  cls_word;
   logic [31:0]                    n_wide;
   logic [CW-1:0]                  pos_wide;
   logic [hdcvt_pkg::LABEL_W-1:0]  o_label_ff;
   logic [hdcvt_pkg::POS_W-1:0]    o_pos_ff;
   logic [hdcvt_pkg::CHUNK_W-1:0]  o_bits_ff;
   logic                           o_ok_ff;
   logic                           o_last_ff;
   logic [hdcvt_pkg::SAMPLE_W-1:0] o_count_ff;

   for (genvar j = 0; j < hdcvt_pkg::CHUNK_W; j++) begin : g_cls_out
      if (j < LANES) begin : g_lane
         assign cls_word[j] = lane_class[j];
      end else begin : g_zero
         assign cls_word[j] = 1'b0;
      end
   end

   assign n_wide   = 32'(st_n_ff);
   assign pos_wide = CW'(st_pos_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         o_label_ff <= st_label_ff;
         o_pos_ff   <= pos_wide[hdcvt_pkg::POS_W-1:0];
         o_bits_ff  <= st_ok_ff ? cls_word : '0;
         o_ok_ff    <= st_ok_ff;
         o_last_ff  <= st_last_ff;
         o_count_ff <= st_ok_ff ? n_wide[hdcvt_pkg::SAMPLE_W-1:0] : '0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.label_echo     = o_label_ff;
   assign rsp_ch.chunk_position = o_pos_ff;
   assign rsp_ch.class_bits     = o_bits_ff;
   assign rsp_ch.accepted       = o_ok_ff;
   assign rsp_ch.vector_done    = o_last_ff;
   assign rsp_ch.sample_count   = o_count_ff;

endmodule

>>> rtl/hdcvt_counter_mem.sv
// ============================================================================
// hdcvt_counter_mem: dimension counter memory
// One row per class and chunk position, holding the counters of all lanes.
// One write port and one read port with registered read data.
// ============================================================================
module hdcvt_counter_mem #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 512,
   parameter int AW    = 9
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data register holds its value until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hdcvt_lane_update.sv
// ============================================================================
// hdcvt_lane_update: per-lane counter update and binarization
// Adds each input bit to its lane counter with saturation and compares the
// new count against the majority threshold.
// ============================================================================
module hdcvt_lane_update #(
   parameter int LANES         = 32,
   parameter int COUNTER_WIDTH = 16
) (
   input  logic [LANES*COUNTER_WIDTH-1:0] rd_row,
   input  logic [LANES-1:0]               lane_bits,
   input  logic [COUNTER_WIDTH-1:0]       threshold,
   output logic [LANES*COUNTER_WIDTH-1:0] wr_row,
   output logic [LANES-1:0]               lane_class
);

   localparam logic [COUNTER_WIDTH-1:0] SAT_MAX = '1;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [COUNTER_WIDTH-1:0] cnt_old;
      logic [COUNTER_WIDTH-1:0] cnt_new;

      assign cnt_old = rd_row[i*COUNTER_WIDTH +: COUNTER_WIDTH];

      always_comb begin
         cnt_new = cnt_old;
         if (lane_bits[i] && (cnt_old != SAT_MAX)) begin
            cnt_new = cnt_old + COUNTER_WIDTH'(1);
         end
      end

      assign wr_row[i*COUNTER_WIDTH +: COUNTER_WIDTH] = cnt_new;
      assign lane_class[i] = (cnt_new > threshold);
   end

endmodule

>>> dv/hdcvt_trainer_checker.sv
// ============================================================================
// hdcvt_trainer_checker: result predictor and comparator for the trainer
// Watches the chunk, result and register channels, keeps its own copy of the
// class counters, and checks every result word against its prediction.
// ============================================================================
module hdcvt_trainer_checker (
   input  logic clock,
   input  logic reset,
   hdcvt_req_if req_ch,
   hdcvt_rsp_if rsp_ch,
   hdcvt_csr_if csr_ch,
   output int   fail_count,
   output int   words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLASS_LIMIT = hdcvt_pkg::MAX_CLASSES_DEF;
   localparam int N_WORDS     = hdcvt_pkg::MAX_DIM_WORDS_DEF;
   localparam int N_LANES     = hdcvt_pkg::LANES_DEF;
   localparam int CNT_W       = hdcvt_pkg::COUNTER_WIDTH_DEF;
   localparam int N_CELLS     = CLASS_LIMIT * N_WORDS * N_LANES;

   typedef struct packed {
      logic [hdcvt_pkg::LABEL_W-1:0]  label_echo;
      logic [hdcvt_pkg::POS_W-1:0]    chunk_position;
      logic [hdcvt_pkg::CHUNK_W-1:0]  class_bits;
      logic                           accepted;
      logic                           vector_done;
      logic [hdcvt_pkg::SAMPLE_W-1:0] sample_count;
   } result_word_type;

   logic [CNT_W-1:0]               dim_count [N_CELLS];
   logic [CNT_W-1:0]               class_samples [CLASS_LIMIT];
   logic [hdcvt_pkg::POS_W-1:0]    next_pos;
   logic [hdcvt_pkg::ACTIVE_W-1:0] active_classes;
   logic [hdcvt_pkg::DIMW_W-1:0]   dim_words;
   result_word_type                predicted_words [$];

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Applies one chunk to the counter copy and returns the result it must cause.
   function automatic result_word_type train_chunk(
      input logic [hdcvt_pkg::LABEL_W-1:0] label,
      input logic [hdcvt_pkg::CHUNK_W-1:0] bits);
      result_word_type w;
      int words, pos, base;
      logic [CNT_W-1:0] n;
      logic last, ok;
      words = (dim_words == 0) ? 1 : ((dim_words > N_WORDS) ? N_WORDS : int'(dim_words));
      pos   = int'(next_pos);
      last  = (pos + 1 >= words);
      ok    = (label < active_classes) && (label < CLASS_LIMIT);
      w = '0;
      w.label_echo     = label;
      w.chunk_position = pos[hdcvt_pkg::POS_W-1:0];
      w.accepted       = ok;
      w.vector_done    = last;
      if (ok) begin
         n    = bump(class_samples[label]);
         base = (int'(label) * N_WORDS + pos) * N_LANES;
         for (int i = 0; i < N_LANES; i++) begin
            if (bits[i]) dim_count[base + i] = bump(dim_count[base + i]);
            if (dim_count[base + i] > (n >> 1)) w.class_bits[i] = 1'b1;
         end
         if (last) class_samples[label] = n;
         w.sample_count = n;
      end
      next_pos = last ? '0 : hdcvt_pkg::POS_W'(pos + 1);
      return w;
   endfunction

   always @(posedge clock) begin
      result_word_type got, want;
      if (reset) begin
         for (int i = 0; i < N_CELLS; i++) dim_count[i] = '0;
         for (int i = 0; i < CLASS_LIMIT; i++) class_samples[i] = '0;
         next_pos       = '0;
         active_classes = hdcvt_pkg::ACTIVE_CLASSES_RST;
         dim_words      = hdcvt_pkg::DIM_WORDS_RST;
         predicted_words.delete();
         fail_count     = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.label_echo, rsp_ch.chunk_position, rsp_ch.class_bits,
                   rsp_ch.accepted, rsp_ch.vector_done, rsp_ch.sample_count};
            if (predicted_words.size() == 0) begin
               fail_count++;
               $display({"%0t: unexpected result word: label %0d pos %0d bits %h",
                         " acc %b done %b cnt %0d"},
                        $time, got.label_echo, got.chunk_position, got.class_bits,
                        got.accepted, got.vector_done, got.sample_count);
            end else begin
               want = predicted_words.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display({"%0t: result mismatch: expected label %0d pos %0d bits %h acc %b",
                            " done %b cnt %0d, actual label %0d pos %0d bits %h acc %b",
                            " done %b cnt %0d"},
                           $time, want.label_echo, want.chunk_position, want.class_bits,
                           want.accepted, want.vector_done, want.sample_count,
                           got.label_echo, got.chunk_position, got.class_bits,
                           got.accepted, got.vector_done, got.sample_count);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            predicted_words.push_back(train_chunk(req_ch.train_label, req_ch.chunk_bits));
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == hdcvt_pkg::REG_ACTIVE_CLASSES)
               active_classes = csr_ch.data[hdcvt_pkg::ACTIVE_W-1:0];
            else if (csr_ch.index == hdcvt_pkg::REG_DIM_WORDS)
               dim_words = csr_ch.data[hdcvt_pkg::DIMW_W-1:0];
         end
      end
      words_pending <= predicted_words.size();
   end

endmodule

>>> dv/tb_hd_class_vector_trainer_core.sv
// ============================================================================
// tb_hd_class_vector_trainer_core: testbench top for the class vector trainer
// Drives training chunks and register writes with random idling on both
// sides, leaves prediction and checking to the checker, and gives the verdict.
// ============================================================================
module tb_hd_class_vector_trainer_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   // Cycles with no word moving on any channel before the run is declared hung.
   // The clearing pass after reset and the long receiver hold
   // (LONG_HOLD) are the longest quiet stretches of a correct run.
   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 400;
   // A result word passes the memory read and output registers after its chunk; this is ample margin.
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdcvt_req_if req_ch ();
   hdcvt_rsp_if rsp_ch ();
   hdcvt_csr_if csr_ch ();

   int   chk_errors;
   int   chk_pending;
   int   send_idle_pct = 16;
   int   recv_idle_pct = 72;
   logic hold_armed    = 1'b0;
   int   quiet_cycles  = 0;

   hd_class_vector_trainer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   hdcvt_trainer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (chk_errors),
      .words_pending (chk_pending)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The watchdog ends the run when no word has moved for too long, which also
   // catches a result that never arrives.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side. Ready is redrawn every cycle from the current idle rate. Once
   // armed, it is held low for one long hold (LONG_HOLD) so the block backs up and
   // has to stall the chunk channel.
   initial begin : receiver
      int   hold_left;
      logic hold_done;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offers one chunk, after random idle cycles, and returns at the falling
   // edge after it was taken. Valid stays high so back-to-back words are
   // possible; it is only lowered by an idle cycle or by drain_results.
   task automatic send_chunk(input logic [hdcvt_pkg::LABEL_W-1:0] label,
                             input logic [hdcvt_pkg::CHUNK_W-1:0] bits);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.train_label <= label;
      req_ch.chunk_bits  <= bits;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering chunks and waits for every predicted result word.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (chk_pending != 0);
   endtask

   // Register write. Bits above the field are filled at random, since the
   // block must ignore them.
   task automatic write_csr(input logic [hdcvt_pkg::CSR_INDEX_W-1:0] index,
                            input int value, input int width);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= ((32'($urandom()) >> width) << width) | 32'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Chunk contents: uniform, sparse, dense or solid, so that some counters
   // drift well away from the threshold while others hover right around it.
   function automatic logic [hdcvt_pkg::CHUNK_W-1:0] pick_chunk();
      case ($urandom_range(0, 5))
         0:       return $urandom() & $urandom();
         1:       return $urandom() | $urandom();
         2:       return {hdcvt_pkg::CHUNK_W{1'($urandom_range(0, 1))}};
         default: return $urandom();
      endcase
   endfunction

   // Random training under one register setting. Most traffic is whole vectors
   // of one in-range class, with the odd chunk of a foreign label mixed in; the
   // rest is cut-short vectors and lone chunks with arbitrary labels. Only
   // chunks the block actually trains on count toward n_items.
   task automatic train_phase(input int n_items, input int act, input int words,
                              input bit with_hold);
      int sent, len, kind, act_lim;
      logic [hdcvt_pkg::LABEL_W-1:0] lbl, c_lbl;
      drain_results();
      write_csr(hdcvt_pkg::REG_ACTIVE_CLASSES, act, hdcvt_pkg::ACTIVE_W);
      write_csr(hdcvt_pkg::REG_DIM_WORDS, words, hdcvt_pkg::DIMW_W);
      if (with_hold) hold_armed <= 1'b1;
      act_lim = (act > hdcvt_pkg::MAX_CLASSES_DEF) ? hdcvt_pkg::MAX_CLASSES_DEF : act;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         lbl  = hdcvt_pkg::LABEL_W'($urandom_range(0, act_lim - 1));
         if (kind < 80) begin
            len = words;
         end else if (kind < 90) begin
            len = $urandom_range(1, words);
         end else begin
            len = 1;
            lbl = hdcvt_pkg::LABEL_W'($urandom_range(0, 255));
         end
         for (int k = 0; k < len; k++) begin
            c_lbl = ($urandom_range(0, 99) < 6) ?
                    hdcvt_pkg::LABEL_W'($urandom_range(0, 255)) : lbl;
            send_chunk(c_lbl, pick_chunk());
            if (c_lbl < act_lim) sent++;
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid       = 1'b0;
      req_ch.train_label = '0;
      req_ch.chunk_bits  = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, under the reset setting of 16 classes and 32 words.
      // Chunks are held off by the block until its clearing pass is over.
      send_chunk(8'd0,   32'h0000_0000);
      send_chunk(8'd15,  32'hFFFF_FFFF);   // highest class in range
      send_chunk(8'd16,  32'hAAAA_AAAA);   // first label past the range
      send_chunk(8'd255, 32'h5555_5555);   // largest label, ignored

      // Shrinking the vector below the current position makes the next chunk
      // the last one, and the position wraps.
      drain_results();
      write_csr(hdcvt_pkg::REG_DIM_WORDS, 2, hdcvt_pkg::DIMW_W);
      send_chunk(8'd1, 32'hFFFF_FFFF);
      // A vector started by class 1 and finished by class 2: only class 2
      // gets its sample count raised.
      send_chunk(8'd1, 32'h1234_5678);
      send_chunk(8'd2, 32'hFFFF_0000);

      // A word count of zero behaves as one word.
      drain_results();
      write_csr(hdcvt_pkg::REG_DIM_WORDS, 0, hdcvt_pkg::DIMW_W);
      send_chunk(8'd3, 32'hFFFF_FFFF);
      send_chunk(8'd3, 32'h0F0F_0F0F);

      // An oversized word count is clamped to the largest vector.
      drain_results();
      write_csr(hdcvt_pkg::REG_DIM_WORDS, 63, hdcvt_pkg::DIMW_W);
      send_chunk(8'd4, 32'h8000_0001);
      send_chunk(8'd4, 32'h7FFF_FFFE);
      drain_results();
      write_csr(hdcvt_pkg::REG_DIM_WORDS, 1, hdcvt_pkg::DIMW_W);
      send_chunk(8'd4, 32'hFFFF_FFFF);

      // Writes to unknown register indexes must leave both registers alone.
      drain_results();
      write_csr(8'd2, 1, 0);
      write_csr(8'hFF, 0, 0);
      send_chunk(8'd5, 32'hC3C3_C3C3);

      // With no active classes every label is ignored.
      drain_results();
      write_csr(hdcvt_pkg::REG_ACTIVE_CLASSES, 0, hdcvt_pkg::ACTIVE_W);
      send_chunk(8'd0, 32'hFFFF_FFFF);

      // An active count above the class store is capped by the store size.
      drain_results();
      write_csr(hdcvt_pkg::REG_ACTIVE_CLASSES, 31, hdcvt_pkg::ACTIVE_W);
      send_chunk(8'd15, 32'hFFFF_FFFF);
      send_chunk(8'd16, 32'hFFFF_FFFF);
      send_chunk(8'd30, 32'hFFFF_FFFF);

      drain_results();
      write_csr(hdcvt_pkg::REG_ACTIVE_CLASSES, 1, hdcvt_pkg::ACTIVE_W);
      send_chunk(8'd0, 32'hFFFF_FFFF);
      send_chunk(8'd1, 32'hFFFF_FFFF);

      // Random part. First the sender idles rarely and the receiver often,
      // with one long receiver hold while chunks keep coming.
      train_phase(450, 16, 4, 1'b1);

      // Then the other way round.
      send_idle_pct = 72;
      recv_idle_pct <= 16;
      train_phase(270, 5, 1, 1'b0);
      train_phase(270, 31, 7, 1'b0);

      // Then no idling at all, with full-length vectors.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      train_phase(540, 16, 32, 1'b0);

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (chk_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
